### design/ftdh_pkg.sv
// ftdh_pkg: types, constants and codes for the flow table with deadline heap
// used by ftdh_ctrl, ftdh_dp and the top level; depends on nothing

package ftdh_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CFG_W    = 11;
  localparam int CMP_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // command codes
  localparam logic [2:0] CMD_RESERVE = 3'd0;
  localparam logic [2:0] CMD_FIND    = 3'd1;
  localparam logic [2:0] CMD_TOUCH   = 3'd2;
  localparam logic [2:0] CMD_REMOVE  = 3'd3;
  localparam logic [2:0] CMD_EXPIRE  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_PRESENT  = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;
  localparam logic [1:0] ST_MISSING  = 2'd3;

  // configuration register indexes
  localparam logic REG_FLOW_LIMIT     = 1'b0;
  localparam logic REG_CLEANUP_BUDGET = 1'b1;

  typedef struct packed {
    logic [63:0] addr;
    logic [31:0] ports;
    logic [63:0] dl;
  } entry_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN_RD,
    OP_SCAN_HIT,
    OP_SCAN_NEXT,
    OP_ST_DUP,
    OP_ST_MISS,
    OP_FIND_HIT,
    OP_REJECT,
    OP_INSERT,
    OP_TOUCH_SET,
    OP_EXP_START_CLEAN,
    OP_EXP_START_CMD,
    OP_EXP_RD_TOP,
    OP_EXP_TAKE,
    OP_EXP_END,
    OP_RM_RD_LAST,
    OP_RM_GOT,
    OP_DN_RD_L,
    OP_DN_GOT_L,
    OP_DN_GOT_R,
    OP_DN_MOVE,
    OP_UP_RD,
    OP_UP_MOVE,
    OP_WRITE_E,
    OP_RESULT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_CHK,
    S_DISP_HIT,
    S_DISP_MISS,
    S_RES_DEC,
    S_EXP_CHK,
    S_EXP_TOP,
    S_EXP_END,
    S_RM_LAST,
    S_RM_GOT,
    S_RM_CHK,
    S_DN_CHK,
    S_DN_GOTL,
    S_DN_GOTR,
    S_DN_DEC,
    S_UP_CHK,
    S_UP_GOT,
    S_WR_E,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       idx_end;
    logic       match;
    logic       full;
    logic       exp_go;
    logic       top_due;
    logic       idx_lt_cnt;
    logic       l_ok;
    logic       r_ok;
    logic       sel_child;
    logic       moved;
    logic       at_root;
    logic       parent_le;
    logic       dl_equal;
    logic       dl_later;
    logic       in_expire;
    logic       out_free;
  } ctl_status_t;

endpackage

### design/ftdh_ram.sv
// ftdh_ram: generic single-port-write, single-read RAM with registered read
// no dependencies

module ftdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/ftdh_ctrl.sv
// ftdh_ctrl: sequencer for lookup, heap sifts, removal and expiry
// depends on ftdh_pkg

module ftdh_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ftdh_pkg::ctl_status_t st,
  output ftdh_pkg::dp_op_t      op
);
  import ftdh_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_valid) state_next = S_SCAN;
      S_SCAN:      state_next = st.idx_end ? S_DISP_MISS : S_SCAN_CHK;
      S_SCAN_CHK:  state_next = st.match ? S_DISP_HIT : S_SCAN;
      S_DISP_HIT: begin
        case (st.cmd)
          CMD_TOUCH: begin
            if (st.dl_equal) state_next = S_DONE;
            else if (st.dl_later) state_next = S_DN_CHK;
            else state_next = S_UP_CHK;
          end
          CMD_REMOVE: state_next = S_RM_LAST;
          CMD_EXPIRE: state_next = S_EXP_CHK;
          default:    state_next = S_DONE;
        endcase
      end
      S_DISP_MISS: begin
        case (st.cmd)
          CMD_RESERVE: state_next = st.full ? S_EXP_CHK : S_RES_DEC;
          CMD_EXPIRE:  state_next = S_EXP_CHK;
          default:     state_next = S_DONE;
        endcase
      end
      S_RES_DEC:   state_next = st.full ? S_DONE : S_UP_CHK;
      S_EXP_CHK:   state_next = st.exp_go ? S_EXP_TOP : S_EXP_END;
      S_EXP_TOP:   state_next = st.top_due ? S_RM_LAST : S_EXP_END;
      S_EXP_END:   state_next = (st.cmd == CMD_RESERVE) ? S_RES_DEC : S_DONE;
      S_RM_LAST:   state_next = S_RM_GOT;
      S_RM_GOT:    state_next = S_RM_CHK;
      S_RM_CHK: begin
        if (st.idx_lt_cnt) state_next = S_DN_CHK;
        else state_next = st.in_expire ? S_EXP_CHK : S_DONE;
      end
      S_DN_CHK: begin
        if (st.l_ok) state_next = S_DN_GOTL;
        else if (st.cmd == CMD_TOUCH || st.moved) state_next = S_WR_E;
        else state_next = S_UP_CHK;
      end
      S_DN_GOTL:   state_next = st.r_ok ? S_DN_GOTR : S_DN_DEC;
      S_DN_GOTR:   state_next = S_DN_DEC;
      S_DN_DEC: begin
        if (st.sel_child) state_next = S_DN_CHK;
        else if (st.cmd == CMD_TOUCH || st.moved) state_next = S_WR_E;
        else state_next = S_UP_CHK;
      end
      S_UP_CHK:    state_next = st.at_root ? S_WR_E : S_UP_GOT;
      S_UP_GOT:    state_next = st.parent_le ? S_WR_E : S_UP_CHK;
      S_WR_E:      state_next = st.in_expire ? S_EXP_CHK : S_DONE;
      S_DONE:      if (st.out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    op       = OP_NONE;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = OP_LOAD;
      end
      S_SCAN:      if (!st.idx_end) op = OP_SCAN_RD;
      S_SCAN_CHK:  op = st.match ? OP_SCAN_HIT : OP_SCAN_NEXT;
      S_DISP_HIT: begin
        case (st.cmd)
          CMD_RESERVE: op = OP_ST_DUP;
          CMD_FIND:    op = OP_FIND_HIT;
          CMD_TOUCH:   if (!st.dl_equal) op = OP_TOUCH_SET;
          CMD_EXPIRE:  op = OP_EXP_START_CMD;
          default:     op = OP_NONE;
        endcase
      end
      S_DISP_MISS: begin
        case (st.cmd)
          CMD_RESERVE: if (st.full) op = OP_EXP_START_CLEAN;
          CMD_FIND,
          CMD_TOUCH,
          CMD_REMOVE:  op = OP_ST_MISS;
          CMD_EXPIRE:  op = OP_EXP_START_CMD;
          default:     op = OP_NONE;
        endcase
      end
      S_RES_DEC:   op = st.full ? OP_REJECT : OP_INSERT;
      S_EXP_CHK:   if (st.exp_go) op = OP_EXP_RD_TOP;
      S_EXP_TOP:   if (st.top_due) op = OP_EXP_TAKE;
      S_EXP_END:   op = OP_EXP_END;
      S_RM_LAST:   op = OP_RM_RD_LAST;
      S_RM_GOT:    op = OP_RM_GOT;
      S_DN_CHK:    if (st.l_ok) op = OP_DN_RD_L;
      S_DN_GOTL:   op = OP_DN_GOT_L;
      S_DN_GOTR:   op = OP_DN_GOT_R;
      S_DN_DEC:    if (st.sel_child) op = OP_DN_MOVE;
      S_UP_CHK:    if (!st.at_root) op = OP_UP_RD;
      S_UP_GOT:    if (!st.parent_le) op = OP_UP_MOVE;
      S_WR_E:      op = OP_WRITE_E;
      S_DONE:      if (st.out_free) op = OP_RESULT;
      default:     op = OP_NONE;
    endcase
  end

endmodule

### design/ftdh_dp.sv
// ftdh_dp: heap storage, key and element registers, counters and result register
// depends on ftdh_pkg and ftdh_ram

module ftdh_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  ftdh_pkg::dp_op_t      op,
  output ftdh_pkg::ctl_status_t st,
  input  logic [2:0]            in_cmd,
  input  logic [31:0]           in_low_address,
  input  logic [31:0]           in_high_address,
  input  logic [15:0]           in_lo_port,
  input  logic [15:0]           in_hi_port,
  input  logic [63:0]           in_now_time,
  input  logic [63:0]           in_deadline,
  input  logic [10:0]           in_expire_budget,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [10:0]           cfg_wdata,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [63:0]           out_found_deadline,
  output logic [10:0]           out_removed_count,
  output logic [10:0]           out_live_count,
  output logic [63:0]           out_rejected_total
);
  import ftdh_pkg::*;

  // command and key registers
  logic [2:0]       cmd;
  logic [63:0]      key_addr;
  logic [31:0]      key_ports;
  logic [63:0]      now_t;
  logic [63:0]      new_dl;
  logic [10:0]      ebud;
  // heap state and work registers
  logic [CNT_W-1:0] cnt;
  logic [63:0]      rej;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] sidx;
  logic [10:0]      budget;
  logic [10:0]      n;
  entry_t           cur;
  entry_t           child;
  logic             sel_child;
  logic             moved;
  logic             in_expire;
  logic [1:0]       status;
  logic [63:0]      fdl;
  logic [CFG_W-1:0] flow_limit;
  logic [CFG_W-1:0] cleanup_budget;

  // memory port
  logic              we;
  logic [ADDR_W-1:0] waddr;
  entry_t            wdata;
  logic [ADDR_W-1:0] raddr;
  entry_t            rdata;

  logic [CNT_W:0]   lidx;
  logic [CNT_W:0]   ridx;
  logic [CNT_W-1:0] pidx;
  logic [CNT_W-1:0] last;
  logic [CMP_W-1:0] limit;
  logic [63:0]      best_dl;

  ftdh_ram #(.WIDTH($bits(entry_t)), .DEPTH(CAPACITY)) u_heap (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // heap index arithmetic
  assign lidx    = {idx, 1'b1};
  assign ridx    = {idx, 1'b0} + (CNT_W + 1)'(2);
  assign pidx    = (idx - CNT_W'(1)) >> 1;
  assign last    = cnt - CNT_W'(1);
  assign limit   = (CMP_W'(flow_limit) > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY)
                                                           : CMP_W'(flow_limit);
  assign best_dl = sel_child ? child.dl : cur.dl;

  // status towards the controller
  always_comb begin
    st            = '0;
    st.cmd        = cmd;
    st.idx_end    = idx >= cnt;
    st.match      = (rdata.addr == key_addr) && (rdata.ports == key_ports);
    st.full       = CMP_W'(cnt) >= limit;
    st.exp_go     = (n < budget) && (cnt != '0);
    st.top_due    = rdata.dl <= now_t;
    st.idx_lt_cnt = idx < cnt;
    st.l_ok       = lidx < {1'b0, cnt};
    st.r_ok       = ridx < {1'b0, cnt};
    st.sel_child  = sel_child;
    st.moved      = moved;
    st.at_root    = idx == '0;
    st.parent_le  = rdata.dl <= cur.dl;
    st.dl_equal   = cur.dl == new_dl;
    st.dl_later   = new_dl > cur.dl;
    st.in_expire  = in_expire;
    st.out_free   = !out_valid || out_ready;
  end

  // memory addressing per command
  always_comb begin
    we    = 1'b0;
    waddr = idx[ADDR_W-1:0];
    wdata = cur;
    raddr = '0;
    case (op)
      OP_SCAN_RD:    raddr = idx[ADDR_W-1:0];
      OP_EXP_RD_TOP: raddr = '0;
      OP_RM_RD_LAST: raddr = last[ADDR_W-1:0];
      OP_DN_RD_L:    raddr = lidx[ADDR_W-1:0];
      OP_DN_GOT_L:   raddr = ridx[ADDR_W-1:0];
      OP_UP_RD:      raddr = pidx[ADDR_W-1:0];
      OP_DN_MOVE: begin
        we    = 1'b1;
        wdata = child;
      end
      OP_UP_MOVE: begin
        we    = 1'b1;
        wdata = rdata;
      end
      OP_WRITE_E:    we = 1'b1;
      default:       raddr = '0;
    endcase
  end

  // control registers: counts, flags, configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt            <= '0;
      rej            <= '0;
      in_expire      <= 1'b0;
      out_valid      <= 1'b0;
      flow_limit     <= CFG_W'(1024);
      cleanup_budget <= CFG_W'(16);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FLOW_LIMIT:     flow_limit <= cfg_wdata;
          REG_CLEANUP_BUDGET: cleanup_budget <= cfg_wdata;
          default:            flow_limit <= flow_limit;
        endcase
      end
      if (op == OP_RESULT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (op)
        OP_LOAD:            in_expire <= 1'b0;
        OP_REJECT:          rej <= rej + 64'd1;
        OP_INSERT:          cnt <= cnt + CNT_W'(1);
        OP_EXP_START_CLEAN: in_expire <= 1'b1;
        OP_EXP_START_CMD:   in_expire <= 1'b1;
        OP_EXP_END:         in_expire <= 1'b0;
        OP_RM_GOT:          cnt <= last;
        default:            cnt <= cnt;
      endcase
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        cmd       <= in_cmd;
        key_addr  <= {in_low_address, in_high_address};
        key_ports <= {in_lo_port, in_hi_port};
        now_t     <= in_now_time;
        new_dl    <= in_deadline;
        ebud      <= in_expire_budget;
        idx       <= '0;
        n         <= '0;
        status    <= ST_DONE;
        fdl       <= '0;
      end
      OP_SCAN_HIT:        cur <= rdata;
      OP_SCAN_NEXT:       idx <= idx + CNT_W'(1);
      OP_ST_DUP:          status <= ST_PRESENT;
      OP_ST_MISS:         status <= ST_MISSING;
      OP_FIND_HIT:        fdl <= cur.dl;
      OP_REJECT:          status <= ST_REJECTED;
      OP_INSERT: begin
        cur   <= '{addr: key_addr, ports: key_ports, dl: new_dl};
        idx   <= cnt;
        moved <= 1'b0;
      end
      OP_TOUCH_SET: begin
        cur.dl <= new_dl;
        moved  <= 1'b0;
      end
      OP_EXP_START_CLEAN: budget <= cleanup_budget;
      OP_EXP_START_CMD:   budget <= ebud;
      OP_EXP_TAKE: begin
        n   <= n + 11'd1;
        idx <= '0;
      end
      OP_RM_GOT: begin
        cur   <= rdata;
        moved <= 1'b0;
      end
      OP_DN_GOT_L: begin
        if (rdata.dl < cur.dl) begin
          child     <= rdata;
          sidx      <= lidx[CNT_W-1:0];
          sel_child <= 1'b1;
        end else begin
          sel_child <= 1'b0;
        end
      end
      OP_DN_GOT_R: begin
        if (rdata.dl < best_dl) begin
          child     <= rdata;
          sidx      <= ridx[CNT_W-1:0];
          sel_child <= 1'b1;
        end
      end
      OP_DN_MOVE: begin
        idx   <= sidx;
        moved <= 1'b1;
      end
      OP_UP_MOVE:         idx <= pidx;
      OP_RESULT: begin
        out_status         <= status;
        out_found_deadline <= fdl;
        out_removed_count  <= n;
        out_live_count     <= 11'(cnt);
        out_rejected_total <= rej;
      end
      default:            idx <= idx;
    endcase
  end

endmodule

### design/flow_table_with_deadline_heap.sv
// flow_table_with_deadline_heap: top level of the flow table with deadline heap
// depends on ftdh_pkg, ftdh_ctrl, ftdh_dp and ftdh_ram

// Keeps up to CAPACITY (1024) flows keyed by a 4-tuple in one heap memory ordered
// by deadline; one command is taken at a time and answered with one result.
// Key lookup walks the live slots one at a time, reading and then comparing each,
// so every command visits up to live_count slots; a heap sift then reads and
// compares per level (up to 10 levels), each expired entry one removal and sift,
// all bound by the single read and single write port of the heap memory.
// A new command is taken while the previous result still waits on the output.
// The heap memory needs no clearing after reset; configuration must be written only
// while the block is idle, which the block itself does not enforce.

module flow_table_with_deadline_heap (
  input  logic          clk,
  input  logic          rst,
  // cmd[2:0], low_address[34:3], high_address[66:35], lo_port[82:67],
  // hi_port[98:83], now_time[162:99], deadline[226:163],
  // expire_budget[237:227], zero[239:238]
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [239:0]  s_tdata,
  // status[1:0], found_deadline[65:2], removed_count[76:66],
  // live_count[87:77], rejected_total[151:88]
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [151:0]  m_tdata,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [10:0]   cfg_wdata
);
  import ftdh_pkg::*;

  dp_op_t      op;
  ctl_status_t st;
  logic        in_ready;

  assign s_tready = in_ready;

  // command sequencer
  ftdh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (in_ready),
    .st       (st),
    .op       (op)
  );

  // storage and arithmetic
  ftdh_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .op                 (op),
    .st                 (st),
    .in_cmd             (s_tdata[2:0]),
    .in_low_address     (s_tdata[34:3]),
    .in_high_address    (s_tdata[66:35]),
    .in_lo_port         (s_tdata[82:67]),
    .in_hi_port         (s_tdata[98:83]),
    .in_now_time        (s_tdata[162:99]),
    .in_deadline        (s_tdata[226:163]),
    .in_expire_budget   (s_tdata[237:227]),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_ready          (m_tready),
    .out_valid          (m_tvalid),
    .out_status         (m_tdata[1:0]),
    .out_found_deadline (m_tdata[65:2]),
    .out_removed_count  (m_tdata[76:66]),
    .out_live_count     (m_tdata[87:77]),
    .out_rejected_total (m_tdata[151:88])
  );

endmodule
